FILE: src/msd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Microphone nudge steering detector package
// Shared constants, register codes and structs of the detector.
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int FRACTION_BITS_DEF = 20;

	localparam int AVG_START   = 200;
	localparam int DRIVE_BITS  = 8;
	localparam int CFG_BITS    = 8;
	localparam int INDEX_BITS  = 2;

	localparam logic [DRIVE_BITS-1:0] MARGIN_RST = 8'd30;
	localparam logic [DRIVE_BITS-1:0] STEER_RST  = 8'd150;
	localparam logic [DRIVE_BITS-1:0] BOOST_RST  = 8'd200;

	typedef enum logic [INDEX_BITS-1:0] {
		CFG_MOVE_EN = 2'd0,
		CFG_MARGIN  = 2'd1,
		CFG_STEER   = 2'd2,
		CFG_BOOST   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SRC_NONE  = 2'd0,
		SRC_FR    = 2'd1,
		SRC_REAR  = 2'd2,
		SRC_FL    = 2'd3
	} nudge_src_t;

	typedef struct packed {
		logic fr;
		logic rear;
		logic fl;
	} lane_hits_t;

	typedef struct packed {
		logic                  move_en;
		logic [DRIVE_BITS-1:0] steer;
		logic [DRIVE_BITS-1:0] boost;
	} drive_cfg_t;

endpackage
`default_nettype wire

FILE: src/msd_mic_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Microphone sample channel
// Valid/ready channel that carries one sample of each of the three microphones.
// ----------------------------------------------------------------------------
interface msd_mic_if #(
	parameter int SAMPLE_BITS = msd_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] front_right_mic;
	logic [SAMPLE_BITS-1:0] rear_mic;
	logic [SAMPLE_BITS-1:0] front_left_mic;

	modport source (output valid, front_right_mic, rear_mic, front_left_mic, input ready);
	modport sink (input valid, front_right_mic, rear_mic, front_left_mic, output ready);
endinterface
`default_nettype wire

FILE: src/msd_drive_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor drive channel
// Valid/ready channel that carries the drive values and the nudge source.
// ----------------------------------------------------------------------------
interface msd_drive_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_drive;
	logic [7:0] right_drive;
	logic       drive_active;
	logic [1:0] nudge_source;

	modport source (output valid, left_drive, right_drive, drive_active, nudge_source,
		input ready);
	modport sink (input valid, left_drive, right_drive, drive_active, nudge_source,
		output ready);
endinterface
`default_nettype wire

FILE: src/mic_nudge_steering_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Microphone nudge steering detector
// Three lanes track running microphone averages and a merge stage turns the
// first nudge found into left and right motor drives.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the lane registers, then the output
// register of the merge stage. Throughput: one item per cycle while the drive
// channel takes items; each lane updates its average combinationally with one
// reciprocal multiply. Reset: averages return to 200.0, registers to their
// defaults, both channels empty. No item is lost when the drive channel stalls.
module mic_nudge_steering_detector #(
	parameter int SAMPLE_BITS   = msd_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = msd_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [msd_pkg::INDEX_BITS-1:0]     cfg_index,
	input  logic [msd_pkg::CFG_BITS-1:0]       cfg_data,
	msd_mic_if.sink                            mic,
	msd_drive_if.source                        drive
);
	logic                          move_en_q;
	logic [msd_pkg::CFG_BITS-1:0]  margin_q;
	logic [msd_pkg::CFG_BITS-1:0]  steer_q;
	logic [msd_pkg::CFG_BITS-1:0]  boost_q;
	logic                          valid_s1;
	logic                          accept;
	logic                          advance;
	logic                          hit_fr;
	logic                          hit_rear;
	logic                          hit_fl;
	msd_pkg::lane_hits_t           hits;
	msd_pkg::drive_cfg_t           dcfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_en_q <= 1'b0;
			margin_q  <= msd_pkg::MARGIN_RST;
			steer_q   <= msd_pkg::STEER_RST;
			boost_q   <= msd_pkg::BOOST_RST;
		end else if (cfg_we) begin
			unique case (msd_pkg::cfg_reg_t'(cfg_index))
				msd_pkg::CFG_MOVE_EN: move_en_q <= cfg_data[0];
				msd_pkg::CFG_MARGIN:  margin_q  <= cfg_data;
				msd_pkg::CFG_STEER:   steer_q   <= cfg_data;
				msd_pkg::CFG_BOOST:   boost_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The lane stage moves on whenever the output register is free or emptying.
	assign advance   = !drive.valid || drive.ready;
	assign mic.ready = !valid_s1 || advance;
	assign accept    = mic.valid && mic.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	msd_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_fr (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.sample (mic.front_right_mic),
		.margin (margin_q),
		.hit    (hit_fr)
	);

	msd_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_rear (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.sample (mic.rear_mic),
		.margin (margin_q),
		.hit    (hit_rear)
	);

	msd_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_fl (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.sample (mic.front_left_mic),
		.margin (margin_q),
		.hit    (hit_fl)
	);

	assign hits.fr      = hit_fr;
	assign hits.rear    = hit_rear;
	assign hits.fl      = hit_fl;
	assign dcfg.move_en = move_en_q;
	assign dcfg.steer   = steer_q;
	assign dcfg.boost   = boost_q;

	msd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (valid_s1 && advance),
		.hits   (hits),
		.cfg    (dcfg),
		.drive  (drive)
	);

endmodule
`default_nettype wire

FILE: src/msd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector lane
// Keeps the running average of one microphone and flags a nudge when the
// sample rises above the integer part of the updated average plus the margin.
// ----------------------------------------------------------------------------
module msd_lane #(
	parameter int SAMPLE_BITS   = msd_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = msd_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic [msd_pkg::CFG_BITS-1:0] margin,
	output logic                     hit
);
	localparam int AW  = SAMPLE_BITS + FRACTION_BITS;
	localparam int UW  = AW - 1;
	localparam int MK  = UW + 1;
	localparam int MW  = MK - 6;
	localparam int QW  = UW - 6;
	localparam int KSH = AW - 9;

	localparam logic [63:0] RECIP   = (64'd1 << MK) / 64'd125;
	localparam logic [63:0] KOFF64  = 64'd1 << KSH;
	localparam logic [63:0] BIAS64  = 64'd125 << KSH;
	localparam logic [63:0] START64 = 64'(msd_pkg::AVG_START) << FRACTION_BITS;
	localparam logic [AW:0] KOFF    = KOFF64[AW:0];
	localparam logic [AW:0] BIAS    = BIAS64[AW:0];

	logic [AW-1:0]          avg_q;
	logic [AW-1:0]          avg_next;
	logic [AW-1:0]          sample_ext;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic signed [AW:0]     diff;
	logic signed [AW:0]     diff_sh;
	logic [AW:0]            biased;
	logic [UW-1:0]          u;
	logic [UW+MW-1:0]       prod;
	logic [QW-1:0]          q0;
	logic [UW-1:0]          rem;
	logic [QW-1:0]          q;
	logic [AW:0]            sum;
	logic [SAMPLE_BITS:0]   limit;

	// avg*999 + s is avg*1000 + (s - avg), so the update is avg + floor((s - avg)/1000).
	// The difference is divided by 8 with a shift, lifted by a multiple of 125
	// to stay positive, and divided by 125 through a reciprocal and one correction.
	always_comb begin
		sample_ext = {sample, {FRACTION_BITS{1'b0}}};
		diff       = $signed({1'b0, sample_ext}) - $signed({1'b0, avg_q});
		diff_sh    = diff >>> 3;
		biased     = $unsigned(diff_sh) + BIAS;
		u          = biased[UW-1:0];
		prod       = u * RECIP[MW-1:0];
		q0         = prod[MK +: QW];
		rem        = u - ({{(UW-QW){1'b0}}, q0} * UW'(125));
		q          = q0 + QW'(rem >= UW'(125));
		sum        = {1'b0, avg_q} + {{(AW+1-QW){1'b0}}, q} - KOFF;
		avg_next   = sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= START64[AW-1:0];
		end else if (load) begin
			avg_q <= avg_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1 <= sample;
		end
	end

	// avg_q already holds the average updated by the item in sample_s1.
	assign limit = {1'b0, avg_q[AW-1:FRACTION_BITS]}
		+ {{(SAMPLE_BITS+1-msd_pkg::CFG_BITS){1'b0}}, margin};
	assign hit = {1'b0, sample_s1} > limit;

endmodule
`default_nettype wire

FILE: src/msd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector merge stage
// Picks the first lane that flagged a nudge, forms the gated drive values
// and holds them in the output register until taken.
// ----------------------------------------------------------------------------
module msd_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  msd_pkg::lane_hits_t hits,
	input  msd_pkg::drive_cfg_t cfg,
	msd_drive_if.source         drive
);
	logic                 valid_q;
	logic [7:0]           left_q;
	logic [7:0]           right_q;
	logic                 active_q;
	msd_pkg::nudge_src_t  source_q;
	logic [7:0]           left_raw;
	logic [7:0]           right_raw;
	msd_pkg::nudge_src_t  source_d;

	// Negative drives of a front nudge clamp to zero.
	always_comb begin
		left_raw  = '0;
		right_raw = '0;
		source_d  = msd_pkg::SRC_NONE;
		if (hits.fr) begin
			right_raw = cfg.steer;
			source_d  = msd_pkg::SRC_FR;
		end else if (hits.rear) begin
			left_raw  = cfg.boost;
			right_raw = cfg.boost;
			source_d  = msd_pkg::SRC_REAR;
		end else if (hits.fl) begin
			left_raw  = cfg.steer;
			source_d  = msd_pkg::SRC_FL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (drive.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q   <= cfg.move_en ? left_raw : 8'd0;
			right_q  <= cfg.move_en ? right_raw : 8'd0;
			active_q <= cfg.move_en;
			source_q <= source_d;
		end
	end

	assign drive.valid        = valid_q;
	assign drive.left_drive   = left_q;
	assign drive.right_drive  = right_q;
	assign drive.drive_active = active_q;
	assign drive.nudge_source = source_q;

endmodule
`default_nettype wire

FILE: src/msd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector port checker
// Watches the drive channel of the detector for consistent results.
// ----------------------------------------------------------------------------
module msd_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] left_drive,
	input  logic [7:0] right_drive,
	input  logic       drive_active,
	input  logic [1:0] nudge_source
);
	// A stalled item keeps its values.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive)
			&& $stable(right_drive) && $stable(nudge_source) && $stable(drive_active))
		else $error("drive item changed while stalled");

	// Disabled movement must never reach the motors.
	a_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_active |-> left_drive == 8'd0 && right_drive == 8'd0)
		else $error("drive nonzero while movement disabled");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nudge_source == msd_pkg::SRC_NONE
			|-> left_drive == 8'd0 && right_drive == 8'd0)
		else $error("drive nonzero without a nudge");

	// A front nudge turns one motor off.
	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (nudge_source == msd_pkg::SRC_FR && left_drive != 8'd0
			|| nudge_source == msd_pkg::SRC_FL && right_drive != 8'd0) |-> 1'b0)
		else $error("front nudge drives the wrong motor");

endmodule

bind mic_nudge_steering_detector msd_checker u_msd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (drive.valid),
	.out_ready    (drive.ready),
	.left_drive   (drive.left_drive),
	.right_drive  (drive.right_drive),
	.drive_active (drive.drive_active),
	.nudge_source (drive.nudge_source)
);
`default_nettype wire

FILE: tb/sv/msd_tb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive scoreboard for the microphone nudge steering detector
// Tracks the three running averages and the register settings, predicts the
// drive item of every accepted sample item and compares the drive items
// that come out of the block with those predictions, oldest first.
// ----------------------------------------------------------------------------
package msd_tb_pkg;

	import msd_pkg::*;

	localparam int                FRAC      = FRACTION_BITS_DEF;
	localparam longint unsigned   AVG_KEEP  = 999;
	localparam longint unsigned   AVG_DIV   = 1000;
	localparam int                DRIVE_MAX = 255;

	typedef struct {
		logic [DRIVE_BITS-1:0] left_drive;
		logic [DRIVE_BITS-1:0] right_drive;
		logic                  drive_active;
		nudge_src_t            nudge_source;
	} drive_item_t;

	class drive_scoreboard;

		bit [63:0]           lane_avg[3];
		bit                  move_en;
		bit [CFG_BITS-1:0]   margin;
		bit [CFG_BITS-1:0]   steer;
		bit [CFG_BITS-1:0]   boost;
		drive_item_t         pending_drives[$];
		int                  mismatches;

		function new();
			foreach (lane_avg[i])
				lane_avg[i] = 64'(AVG_START) << FRAC;
			move_en    = 1'b0;
			margin     = MARGIN_RST;
			steer      = STEER_RST;
			boost      = BOOST_RST;
			mismatches = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_BITS-1:0] val);
			case (idx)
			CFG_MOVE_EN: begin
				move_en = val[0];
			end
			CFG_MARGIN: begin
				margin = val;
			end
			CFG_STEER: begin
				steer = val;
			end
			CFG_BOOST: begin
				boost = val;
			end
			default: begin
			end
			endcase
		endfunction

		// Integer part of the lane's current average plus the margin; the nudge check uses the updated average.
		function int nudge_level(int lane);
			return int'(lane_avg[lane] >> FRAC) + int'(margin);
		endfunction

		function int pending();
			return pending_drives.size();
		endfunction

		function logic [DRIVE_BITS-1:0] clamp_drive(int v);
			if (v > DRIVE_MAX)
				return DRIVE_BITS'(DRIVE_MAX);
			if (v < 0)
				return '0;
			return DRIVE_BITS'(v);
		endfunction

		function void note_samples(logic [SAMPLE_BITS_DEF-1:0] fr, logic [SAMPLE_BITS_DEF-1:0] rear,
			logic [SAMPLE_BITS_DEF-1:0] fl);
			bit [63:0]   smp[3];
			bit          hit[3];
			int          left;
			int          right;
			drive_item_t want;
			smp[0] = 64'(fr);
			smp[1] = 64'(rear);
			smp[2] = 64'(fl);
			// The threshold is taken from the average after this item's update.
			foreach (smp[i]) begin
				lane_avg[i] = (lane_avg[i] * AVG_KEEP + (smp[i] << FRAC)) / AVG_DIV;
				hit[i]      = smp[i] > (lane_avg[i] >> FRAC) + 64'(margin);
			end
			left              = 0;
			right             = 0;
			want.nudge_source = SRC_NONE;
			if (hit[0]) begin
				left              = -int'(steer);
				right             = int'(steer);
				want.nudge_source = SRC_FR;
			end else if (hit[1]) begin
				left              = int'(boost);
				right             = int'(boost);
				want.nudge_source = SRC_REAR;
			end else if (hit[2]) begin
				left              = int'(steer);
				right             = -int'(steer);
				want.nudge_source = SRC_FL;
			end
			want.drive_active = move_en;
			want.left_drive   = move_en ? clamp_drive(left) : '0;
			want.right_drive  = move_en ? clamp_drive(right) : '0;
			pending_drives.push_back(want);
		endfunction

		function void check_drive(drive_item_t got);
			drive_item_t want;
			if (pending_drives.size() == 0) begin
				$error("drive item with none pending: left_drive %0d, right_drive %0d",
					got.left_drive, got.right_drive);
				mismatches++;
				return;
			end
			want = pending_drives.pop_front();
			if (got.left_drive !== want.left_drive) begin
				$error("left_drive: expected %0d, actual %0d", want.left_drive, got.left_drive);
				mismatches++;
			end
			if (got.right_drive !== want.right_drive) begin
				$error("right_drive: expected %0d, actual %0d", want.right_drive, got.right_drive);
				mismatches++;
			end
			if (got.drive_active !== want.drive_active) begin
				$error("drive_active: expected %0d, actual %0d", want.drive_active,
					got.drive_active);
				mismatches++;
			end
			if (got.nudge_source !== want.nudge_source) begin
				$error("nudge_source: expected %0d, actual %0d", want.nudge_source,
					got.nudge_source);
				mismatches++;
			end
		endfunction

	endclass

endpackage
`default_nettype wire

FILE: tb/sv/tb_mic_nudge_steering_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Microphone nudge steering detector testbench
// Drives sample items through a handful of register settings, with random
// gaps on the sample side and random stalls on the drive side, and checks
// every drive item against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_mic_nudge_steering_detector;

	import msd_pkg::*;
	import msd_tb_pkg::*;

	localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS_DEF) - 1;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 213;

	typedef enum int {
		STYLE_ANY,
		STYLE_NEAR,
		STYLE_BELOW,
		STYLE_RAIL
	} sample_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]   cfg_data;
	bit                    steady;
	drive_scoreboard       sb;

	msd_mic_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) mic_ch ();
	msd_drive_if drv_ch ();

	mic_nudge_steering_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mic       (mic_ch),
		.drive     (drv_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("mic_nudge_steering_detector test failed");
		$finish;
	end

	// Mostly short idles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(int lane, sample_style_t style);
		int lvl;
		int v;
		lvl = sb.nudge_level(lane);
		if (lvl > SAMPLE_MAX)
			lvl = SAMPLE_MAX;
		case (style)
		STYLE_NEAR: begin
			v = lvl + int'($urandom_range(0, 4)) - 2;
		end
		STYLE_BELOW: begin
			v = int'($urandom_range(0, lvl));
		end
		STYLE_RAIL: begin
			v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
		end
		default: begin
			v = int'($urandom_range(0, SAMPLE_MAX));
		end
		endcase
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return SAMPLE_BITS_DEF'(v);
	endfunction

	always @(posedge clk) begin
		drive_item_t got;
		if (arst_n && drv_ch.valid && drv_ch.ready) begin
			got.left_drive   = drv_ch.left_drive;
			got.right_drive  = drv_ch.right_drive;
			got.drive_active = drv_ch.drive_active;
			got.nudge_source = nudge_src_t'(drv_ch.nudge_source);
			sb.check_drive(got);
		end
	end

	initial begin
		int stall_left;
		stall_left   = 0;
		drv_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (steady) begin
				drv_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				drv_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				drv_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic send_samples(input logic [SAMPLE_BITS_DEF-1:0] fr,
		input logic [SAMPLE_BITS_DEF-1:0] rear, input logic [SAMPLE_BITS_DEF-1:0] fl);
		int gap;
		gap = steady ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			mic_ch.valid <= 1'b0;
		end
		@(negedge clk);
		mic_ch.valid           <= 1'b1;
		mic_ch.front_right_mic <= fr;
		mic_ch.rear_mic        <= rear;
		mic_ch.front_left_mic  <= fl;
		do
			@(posedge clk);
		while (!mic_ch.ready);
		sb.note_samples(fr, rear, fl);
	endtask

	// Holds the sample side until every pending drive item is out, then lets
	// the pipeline settle.
	task automatic drain_drives();
		@(negedge clk);
		mic_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic apply_settings(input logic en, input logic [CFG_BITS-1:0] margin,
		input logic [CFG_BITS-1:0] steer, input logic [CFG_BITS-1:0] boost);
		drain_drives();
		write_reg(CFG_MOVE_EN, CFG_BITS'(en));
		write_reg(CFG_MARGIN, margin);
		write_reg(CFG_STEER, steer);
		write_reg(CFG_BOOST, boost);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [SAMPLE_BITS_DEF-1:0] smp[3];
		sample_style_t              style;
		int                         r;
		steady                 = 1'b0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_MOVE_EN;
		cfg_data               = '0;
		mic_ch.valid           = 1'b0;
		mic_ch.front_right_mic = '0;
		mic_ch.rear_mic        = '0;
		mic_ch.front_left_mic  = '0;
		sb                     = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: movement is off, yet detection still reports.
		send_samples(12'd0, 12'd0, 12'd0);
		send_samples(12'hFFF, 12'd0, 12'd0);
		send_samples(12'd0, 12'hFFF, 12'd0);
		send_samples(12'd0, 12'd0, 12'hFFF);
		send_samples(12'hFFF, 12'hFFF, 12'hFFF);

		// Widest drives and a zero margin; front nudges clamp one side to zero.
		apply_settings(1'b1, 8'd0, 8'd255, 8'd255);
		send_samples(12'd0, 12'hFFF, 12'hFFF);
		send_samples(12'hFFF, 12'd0, 12'd0);
		send_samples(12'd0, 12'd0, 12'hFFF);
		send_samples(12'd0, 12'd0, 12'd0);
		send_samples(12'hAAA, 12'h555, 12'hAAA);
		send_samples(12'h555, 12'hAAA, 12'h555);

		// Largest margin with zero drive amounts.
		apply_settings(1'b1, 8'd255, 8'd0, 8'd0);
		send_samples(12'hFFF, 12'hFFF, 12'hFFF);
		send_samples(12'd0, 12'hFFF, 12'd0);
		send_samples(12'd0, 12'd0, 12'hFFF);
		send_samples(12'd128, 12'd128, 12'd128);

		apply_settings(1'b1, MARGIN_RST, STEER_RST, BOOST_RST);
		send_samples(12'hFFF, 12'd0, 12'd0);
		send_samples(12'd0, 12'hFFF, 12'd0);
		send_samples(12'd0, 12'd0, 12'hFFF);
		send_samples(12'd0, 12'd0, 12'd0);
		send_samples(12'hFFF, 12'hFFF, 12'hFFF);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
			0: apply_settings(1'b1, MARGIN_RST, STEER_RST, BOOST_RST);
			1: apply_settings(1'b0, 8'd0, 8'd255, 8'd255);
			2: apply_settings(1'b1, 8'd0, 8'd0, 8'd255);
			3: apply_settings(1'b1, 8'd255, 8'd255, 8'd0);
			4: apply_settings(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
			5: apply_settings(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
			6: apply_settings(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
			default: apply_settings(1'b1, 8'd1, 8'd128, 8'd127);
			endcase
			steady = (p == 3) || (p == 6);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 149) == 0)
					drain_drives();
				r = $urandom_range(0, 99);
				foreach (smp[lane]) begin
					if (r < 35)
						style = STYLE_ANY;
					else if (r < 85)
						style = ($urandom_range(0, 4) < 3) ? STYLE_NEAR : STYLE_BELOW;
					else
						style = ($urandom_range(0, 1) != 0) ? STYLE_RAIL : STYLE_ANY;
					smp[lane] = pick_sample(lane, style);
				end
				send_samples(smp[0], smp[1], smp[2]);
			end
		end

		steady = 1'b0;
		drain_drives();
		if (sb.mismatches == 0)
			$display("mic_nudge_steering_detector test passed");
		else
			$display("mic_nudge_steering_detector test failed");
		$finish;
	end

endmodule
`default_nettype wire
